FILE: hdl/tgad_pkg.sv
// tgad_pkg: shared types and constants for the tga stream decoder
// holds the byte and result item structs, parse phases and header offsets
// no dependencies
package tgad_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int DIM_BITS      = 16;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int LOADED_W      = $clog2(PALETTE_DEPTH + 1);
  localparam int AREA_W        = 2 * DIM_BITS;
  localparam int REP_BITS      = 8;
  localparam int REM_W         = DIM_BITS + 1;
  localparam int DIV_W         = DIM_BITS + REP_BITS;

  // image types and colour map entry sizes
  localparam logic [7:0] TYPE_MAPPED = 8'd1;
  localparam logic [7:0] TYPE_TRUE   = 8'd2;
  localparam logic [7:0] TYPE_RLE    = 8'd10;
  localparam logic [7:0] ENTRY_24    = 8'd24;
  localparam logic [7:0] ENTRY_32    = 8'd32;

  // bit masks
  localparam logic [7:0] DESC_TOP = 8'h20;
  localparam logic [7:0] PKT_RUN  = 8'h80;
  localparam logic [7:0] PKT_LEN  = 8'h7F;

  // header byte offsets
  localparam logic [4:0] HB_ID_LEN     = 5'd0;
  localparam logic [4:0] HB_TYPE       = 5'd2;
  localparam logic [4:0] HB_MAP_LEN_LO = 5'd5;
  localparam logic [4:0] HB_MAP_LEN_HI = 5'd6;
  localparam logic [4:0] HB_MAP_BITS   = 5'd7;
  localparam logic [4:0] HB_W_LO       = 5'd12;
  localparam logic [4:0] HB_W_HI       = 5'd13;
  localparam logic [4:0] HB_H_LO       = 5'd14;
  localparam logic [4:0] HB_H_HI       = 5'd15;
  localparam logic [4:0] HB_AREA       = 5'd16;
  localparam logic [4:0] HB_DESC       = 5'd17;

  // run position divider steps: quotient bits 7..5, 4..2, 1..0
  localparam logic [1:0] DIV_IDLE     = 2'd0;
  localparam logic [1:0] DIV_FIRST    = 2'd1;
  localparam logic [1:0] DIV_SECOND   = 2'd2;
  localparam logic [1:0] DIV_LAST_CYC = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_IDSKIP,
    PH_MAP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  repeat_res;
    logic        status;
    logic        last;
  } out_item_t;

  // highest quotient bit handled in a divider cycle
  function automatic logic [2:0] div_top(input logic [1:0] cyc);
    logic [2:0] top;
    unique case (cyc)
      DIV_FIRST:    top = 3'd7;
      DIV_SECOND:   top = 3'd4;
      DIV_LAST_CYC: top = 3'd1;
      default:      top = 3'd0;
    endcase
    return top;
  endfunction

endpackage

FILE: hdl/tga_image_stream_decoder_core.sv
// tga_image_stream_decoder_core: byte-serial tga decoder, header to pixel runs
// depends on tgad_pkg (item structs, phases, header offsets, palette depth)
//
// Takes one file byte per clock while out_stall is low and gives one run result per
// completed colour, or an error result for an unsupported header. A byte is
// registered on entry, decoded from the input register and its result is written
// into the output register. The palette is a 256 x 24 memory read when the index
// byte enters, with a bypass for an entry written in the same cycle. The position
// after a run packet comes from a restoring divider over DIV_FIRST, DIV_SECOND and
// DIV_LAST_CYC (2 to 3 quotient bits a cycle); a new run colour needs at least four
// bytes, so it is always done in time. No clearing pass after reset.
module tga_image_stream_decoder_core
  import tgad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // input register
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_r;
  logic      s1_fire;
  logic      in_accept;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // decode state
  phase_t                phase_r, phase_nxt;
  logic [4:0]            hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]            img_type_r, img_type_nxt;
  logic [7:0]            id_skip_r, id_skip_nxt;
  logic [15:0]           map_left_r, map_left_nxt;
  logic [7:0]            map_bits_r, map_bits_nxt;
  logic [LOADED_W-1:0]   map_loaded_r, map_loaded_nxt;
  logic [DIM_BITS-1:0]   width_r, width_nxt;
  logic [DIM_BITS-1:0]   height_r, height_nxt;
  logic                  top_origin_r, top_origin_nxt;
  logic [1:0]            byte_grp_r, byte_grp_nxt;
  logic [23:0]           held_r, held_nxt;
  logic [7:0]            pkt_left_r, pkt_left_nxt;
  logic                  pkt_run_r, pkt_run_nxt;
  logic [DIM_BITS-1:0]   col_r, col_nxt;
  logic [DIM_BITS-1:0]   row_r, row_nxt;
  logic [AREA_W-1:0]     left_r, left_nxt;

  // run position divider
  logic [1:0]            div_cyc_r, div_cyc_nxt;
  logic [REM_W-1:0]      div_rem_r, div_rem_nxt;
  logic [REP_BITS-1:0]   div_quo_r, div_quo_nxt;

  // palette
  logic [23:0]           palette_mem [PALETTE_DEPTH];
  logic [23:0]           pal_rd_r;
  logic                  pal_byp_r;
  logic [23:0]           pal_bypd_r;
  logic [23:0]           pal_q;
  logic                  pal_we;
  logic [PAL_AW-1:0]     pal_wa;
  logic [PAL_AW-1:0]     pal_ra;
  logic [23:0]           pal_wd;

  assign s1_fire   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pal_ra    = in_data.data_byte[PAL_AW-1:0];
  assign pal_q     = pal_byp_r ? pal_bypd_r : pal_rd_r;

  always_comb begin
    logic [7:0]          b;
    logic [15:0]         dim16;
    logic                ok;
    logic                emit;
    logic                emit_run;
    logic [23:0]         emit_rgb;
    logic [REP_BITS-1:0] emit_rep;
    logic                is_last;
    logic [2:0]          grp_inc;
    logic                entry_done;
    logic [DIV_W-1:0]    rem;
    logic [DIV_W-1:0]    shifted;
    logic [REP_BITS-1:0] quo;
    logic [2:0]          top;
    logic [2:0]          bp;
    logic [DIM_BITS-1:0] col_inc;

    s1_valid_nxt   = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    img_type_nxt   = img_type_r;
    id_skip_nxt    = id_skip_r;
    map_left_nxt   = map_left_r;
    map_bits_nxt   = map_bits_r;
    map_loaded_nxt = map_loaded_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    top_origin_nxt = top_origin_r;
    byte_grp_nxt   = byte_grp_r;
    held_nxt       = held_r;
    pkt_left_nxt   = pkt_left_r;
    pkt_run_nxt    = pkt_run_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    left_nxt       = left_r;
    div_cyc_nxt    = div_cyc_r;
    div_rem_nxt    = div_rem_r;
    div_quo_nxt    = div_quo_r;
    pal_we         = 1'b0;
    pal_wa         = map_loaded_r[PAL_AW-1:0];
    pal_wd         = held_r;

    b          = s1_r.data_byte;
    dim16      = 16'h0;
    ok         = 1'b0;
    emit       = 1'b0;
    emit_run   = 1'b0;
    emit_rgb   = 24'h0;
    emit_rep   = REP_BITS'(1);
    is_last    = 1'b0;
    grp_inc    = 3'd0;
    entry_done = 1'b0;
    rem        = DIV_W'(div_rem_r);
    shifted    = '0;
    quo        = div_quo_r;
    top        = div_top(div_cyc_r);
    bp         = 3'd0;
    col_inc    = col_r + DIM_BITS'(1);

    // restoring division of (col + run length) by width
    if (div_cyc_r != DIV_IDLE) begin
      for (int j = 0; j < 3; j++) begin
        if (!(div_cyc_r == DIV_LAST_CYC && j == 2)) begin
          bp      = top - 3'(j);
          shifted = DIV_W'(width_r) << bp;
          if (rem >= shifted) begin
            rem     = rem - shifted;
            quo[bp] = 1'b1;
          end
        end
      end
      div_rem_nxt = rem[REM_W-1:0];
      div_quo_nxt = quo;
      if (div_cyc_r == DIV_LAST_CYC) begin
        col_nxt     = rem[DIM_BITS-1:0];
        row_nxt     = row_r + DIM_BITS'(quo);
        div_cyc_nxt = DIV_IDLE;
      end else begin
        div_cyc_nxt = div_cyc_r + 2'd1;
      end
    end

    if (s1_fire) begin
      if (s1_r.first_byte) begin
        phase_nxt      = PH_HEADER;
        hdr_cnt_nxt    = '0;
        img_type_nxt   = '0;
        id_skip_nxt    = '0;
        map_left_nxt   = '0;
        map_bits_nxt   = '0;
        map_loaded_nxt = '0;
        width_nxt      = '0;
        height_nxt     = '0;
        top_origin_nxt = 1'b0;
        byte_grp_nxt   = '0;
        held_nxt       = '0;
        pkt_left_nxt   = '0;
        pkt_run_nxt    = 1'b0;
        col_nxt        = '0;
        row_nxt        = '0;
        left_nxt       = '0;
        div_cyc_nxt    = DIV_IDLE;
      end

      unique case (phase_nxt)
        PH_HEADER: begin
          unique case (hdr_cnt_nxt)
            HB_ID_LEN:     id_skip_nxt = b;
            HB_TYPE:       img_type_nxt = b;
            HB_MAP_LEN_LO: map_left_nxt = {8'h0, b};
            HB_MAP_LEN_HI: map_left_nxt = {b, map_left_nxt[7:0]};
            HB_MAP_BITS:   map_bits_nxt = b;
            HB_W_LO: begin
              dim16     = {8'h0, b};
              width_nxt = dim16[DIM_BITS-1:0];
            end
            HB_W_HI: begin
              dim16     = {b, 8'h0} | 16'(width_nxt);
              width_nxt = dim16[DIM_BITS-1:0];
            end
            HB_H_LO: begin
              dim16      = {8'h0, b};
              height_nxt = dim16[DIM_BITS-1:0];
            end
            HB_H_HI: begin
              dim16      = {b, 8'h0} | 16'(height_nxt);
              height_nxt = dim16[DIM_BITS-1:0];
            end
            // total pixel count, once both dimensions are in
            HB_AREA:       left_nxt = AREA_W'(width_nxt) * AREA_W'(height_nxt);
            HB_DESC:       top_origin_nxt = (b & DESC_TOP) != 8'h0;
            default: ;
          endcase
          if (hdr_cnt_nxt == HB_DESC) begin
            hdr_cnt_nxt = '0;
            ok = img_type_nxt == TYPE_TRUE || img_type_nxt == TYPE_RLE ||
                 (img_type_nxt == TYPE_MAPPED &&
                  (map_bits_nxt == ENTRY_24 || map_bits_nxt == ENTRY_32));
            if (!ok) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt.status = 1'b1;
              out_data_nxt.last   = 1'b1;
              phase_nxt     = PH_DONE;
            end else if (id_skip_nxt != 8'h0) begin
              phase_nxt = PH_IDSKIP;
            end else if (img_type_nxt == TYPE_MAPPED && map_left_nxt != 16'h0) begin
              phase_nxt = PH_MAP;
            end else begin
              phase_nxt = PH_PIXELS;
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_nxt + 5'd1;
          end
        end

        PH_IDSKIP: begin
          if (id_skip_nxt != 8'h0) begin
            id_skip_nxt = id_skip_nxt - 8'd1;
          end
          if (id_skip_nxt == 8'h0) begin
            if (img_type_nxt == TYPE_MAPPED && map_left_nxt != 16'h0) begin
              phase_nxt = PH_MAP;
            end else begin
              phase_nxt = PH_PIXELS;
            end
          end
        end

        PH_MAP: begin
          // alpha byte of a 32-bit entry is counted but not held
          if (byte_grp_nxt != 2'd3) begin
            held_nxt = {held_nxt[15:0], b};
          end
          grp_inc    = {1'b0, byte_grp_nxt} + 3'd1;
          entry_done = (map_bits_nxt == ENTRY_32) ? (grp_inc == 3'd4) : (grp_inc == 3'd3);
          if (entry_done) begin
            byte_grp_nxt = '0;
            if (map_loaded_nxt < LOADED_W'(PALETTE_DEPTH)) begin
              pal_we         = 1'b1;
              pal_wa         = map_loaded_nxt[PAL_AW-1:0];
              pal_wd         = held_nxt;
              map_loaded_nxt = map_loaded_nxt + LOADED_W'(1);
            end
            map_left_nxt = map_left_nxt - 16'd1;
            if (map_left_nxt == 16'h0) begin
              phase_nxt = PH_PIXELS;
            end
          end else begin
            byte_grp_nxt = grp_inc[1:0];
          end
        end

        PH_PIXELS: begin
          if (left_nxt == '0) begin
            phase_nxt = PH_DONE;
          end else if (img_type_nxt == TYPE_MAPPED) begin
            emit     = 1'b1;
            emit_rgb = ({1'b0, b} < 9'(map_loaded_nxt)) ? pal_q : 24'h0;
          end else if (img_type_nxt == TYPE_RLE && pkt_left_nxt == 8'h0) begin
            pkt_run_nxt  = (b & PKT_RUN) != 8'h0;
            pkt_left_nxt = (b & PKT_LEN) + 8'd1;
          end else begin
            held_nxt = {held_nxt[15:0], b};
            if (byte_grp_nxt == 2'd2) begin
              byte_grp_nxt = '0;
              emit         = 1'b1;
              emit_rgb     = held_nxt;
              if (img_type_nxt == TYPE_RLE) begin
                if (pkt_run_nxt) begin
                  emit_run     = 1'b1;
                  emit_rep     = (AREA_W'(pkt_left_nxt) < left_nxt) ?
                                 pkt_left_nxt : left_nxt[REP_BITS-1:0];
                  pkt_left_nxt = 8'h0;
                end else begin
                  pkt_left_nxt = pkt_left_nxt - 8'd1;
                end
              end
            end else begin
              byte_grp_nxt = byte_grp_nxt + 2'd1;
            end
          end
        end

        PH_DONE: ;
        default: ;
      endcase

      if (emit) begin
        is_last                 = left_nxt == AREA_W'(emit_rep);
        out_valid_nxt           = 1'b1;
        out_data_nxt.pos_x      = 16'(col_nxt);
        out_data_nxt.pos_y      = top_origin_nxt ? 16'(row_nxt) :
                                  16'(height_nxt - DIM_BITS'(1) - row_nxt);
        out_data_nxt.red        = emit_rgb[7:0];
        out_data_nxt.green      = emit_rgb[15:8];
        out_data_nxt.blue       = emit_rgb[23:16];
        out_data_nxt.repeat_res = emit_rep;
        out_data_nxt.status     = 1'b0;
        out_data_nxt.last       = is_last;
        left_nxt                = left_nxt - AREA_W'(emit_rep);
        if (is_last) begin
          phase_nxt = PH_DONE;
        end
        if (emit_run) begin
          // wrap handled over the next cycles by the divider
          div_rem_nxt = REM_W'(col_nxt) + REM_W'(emit_rep);
          div_quo_nxt = '0;
          div_cyc_nxt = DIV_FIRST;
        end else if (col_inc == width_nxt) begin
          col_nxt = '0;
          row_nxt = row_nxt + DIM_BITS'(1);
        end else begin
          col_nxt = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      img_type_r   <= '0;
      id_skip_r    <= '0;
      map_left_r   <= '0;
      map_bits_r   <= '0;
      map_loaded_r <= '0;
      width_r      <= '0;
      height_r     <= '0;
      top_origin_r <= 1'b0;
      byte_grp_r   <= '0;
      held_r       <= '0;
      pkt_left_r   <= '0;
      pkt_run_r    <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      left_r       <= '0;
      div_cyc_r    <= DIV_IDLE;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      img_type_r   <= img_type_nxt;
      id_skip_r    <= id_skip_nxt;
      map_left_r   <= map_left_nxt;
      map_bits_r   <= map_bits_nxt;
      map_loaded_r <= map_loaded_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      top_origin_r <= top_origin_nxt;
      byte_grp_r   <= byte_grp_nxt;
      held_r       <= held_nxt;
      pkt_left_r   <= pkt_left_nxt;
      pkt_run_r    <= pkt_run_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      left_r       <= left_nxt;
      div_cyc_r    <= div_cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= in_data;
    end
    out_data_r <= out_data_nxt;
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_mem[pal_wa] <= pal_wd;
    end
  end

  // read on transfer in; an entry written at the same edge is forwarded
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pal_rd_r   <= palette_mem[pal_ra];
      pal_byp_r  <= pal_we && (pal_wa == pal_ra);
      pal_bypd_r <= pal_wd;
    end
  end

endmodule

FILE: hdl/tgad_checker.sv
// tgad_checker: port-level checks for the tga stream decoder
// depends on tgad_pkg; bound to tga_image_stream_decoder_core below
module tgad_checker
  import tgad_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled byte holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled byte changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an error result ends the image and carries nothing else
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && out_data.pos_x == 16'h0 &&
      out_data.pos_y == 16'h0 && out_data.red == 8'h0 && out_data.green == 8'h0 &&
      out_data.blue == 8'h0 && out_data.repeat_res == 8'h0)
    else $error("malformed error result");

  // pixel runs cover 1 to 128 pixels
  a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.status |->
      out_data.repeat_res != 8'h0 && out_data.repeat_res <= 8'd128)
    else $error("run length out of range");

  // nothing follows the final result right away: a new header is needed
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("result right after final transfer");

endmodule

bind tga_image_stream_decoder_core tgad_checker u_tgad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
